[rtl/cog_pkg.sv]
// Shared constants, types and helpers for the chunked occupancy grid.
package cog_pkg;

  localparam int CHUNK_DIM       = 16;
  localparam int MAX_CHUNKS      = 16;
  localparam int CELLS_PER_CHUNK = CHUNK_DIM * CHUNK_DIM;
  localparam int MEM_DEPTH       = MAX_CHUNKS * CELLS_PER_CHUNK;

  localparam int KEY_W    = 32;
  localparam int ROW_W    = 4;
  localparam int CELL_W   = 7;
  localparam int VALUE_W  = 8;
  localparam int DIM_W    = $clog2(CHUNK_DIM);
  localparam int SLOT_W   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CNT_W    = $clog2(MAX_CHUNKS + 1);
  localparam int OFF_W    = $clog2(CELLS_PER_CHUNK);
  localparam int ADDR_W   = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 8;

  localparam logic [CELL_W-1:0]  CELL_MAX     = 7'd127;
  localparam logic [VALUE_W-1:0] ABSENT_VALUE = 8'h80;

  typedef enum logic {
    CMD_QUERY = 1'b0,
    CMD_ADD   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_ABSENT = 2'd1,
    STAT_FULL   = 2'd2
  } status_t;

  // Directory lookup outcome handed from the directory to the sequencer.
  typedef struct packed {
    logic              hit;
    logic              full;
    logic [SLOT_W-1:0] slot;
  } dir_res_t;

  // Row and column indexes wrap modulo the chunk size; the input is only
  // four bits wide, so a few conditional subtractions settle it.
  function automatic logic [DIM_W-1:0] wrap_idx(input logic [ROW_W-1:0] v);
    logic [ROW_W-1:0] t;
    t = v;
    for (int i = 0; i < 8; i++) begin
      if (int'(t) >= CHUNK_DIM) begin
        t = ROW_W'(int'(t) - CHUNK_DIM);
      end
    end
    return DIM_W'(t);
  endfunction

endpackage

[rtl/cog_dir.sv]
// Chunk key directory: parallel key match and in-order slot allocation.
module cog_dir (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [cog_pkg::KEY_W-1:0] key,
  input  logic                  alloc,
  output cog_pkg::dir_res_t     res
);
  import cog_pkg::*;

  logic [KEY_W-1:0] key_table [MAX_CHUNKS];
  logic [CNT_W-1:0] slots_used;
  dir_res_t         res_next;

  // Slots are handed out in order and never freed, so a slot is valid
  // exactly when its index is below the fill count.
  always_comb begin
    res_next.hit  = 1'b0;
    res_next.full = (slots_used == CNT_W'(MAX_CHUNKS));
    res_next.slot = slots_used[SLOT_W-1:0];
    for (int s = MAX_CHUNKS - 1; s >= 0; s--) begin
      if ((slots_used > CNT_W'(s)) && (key_table[s] == key)) begin
        res_next.hit  = 1'b1;
        res_next.slot = SLOT_W'(s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used <= '0;
    end else if (alloc) begin
      slots_used <= slots_used + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (alloc) begin
      key_table[slots_used[SLOT_W-1:0]] <= key;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= CNT_W'(MAX_CHUNKS))
    else $error("directory fill count beyond capacity");

  a_no_alloc_full: assert property (@(posedge clk) disable iff (rst)
    alloc |-> slots_used != CNT_W'(MAX_CHUNKS))
    else $error("allocation into a full directory");

endmodule

[rtl/chunked_occupancy_grid_unit.sv]
// Top level of the chunked occupancy grid: sequencer, cell memory and result register.
//
// Input words arrive on the s_ channel: tuser carries the command (query or add),
// tdata carries the chunk key and the cell row and column. Each word produces
// exactly one result word on the m_ channel: tdata is the cell value (-128 when
// a query finds no chunk or an add finds no free slot), tuser is the status code.
//
// One word is worked on at a time and s_tready is high only while the sequencer
// is idle. A word whose chunk is known passes from acceptance to the result
// register through the registered directory match, decision, one read of the
// single-port cell memory, the update or readout, and the result load. A query
// of an absent chunk or an add of an unseen key to a full directory goes from the
// decision straight to the result load. An add with an unseen key first clears
// all CHUNK_DIM * CHUNK_DIM cells (256 here) of the new chunk through the same
// memory port, one cell per cycle, before the cell read.
//
// The result register lets a new word be accepted while the previous result
// waits; a finished result then holds the sequencer until the receiver takes
// the one in front of it. Reset empties the directory and the result register;
// the cell memory needs no clearing because chunks are zeroed on allocation.
module chunked_occupancy_grid_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [cog_pkg::S_TDATA_W-1:0]     s_tdata,  // chunk_key[31:0], cell_row[35:32], cell_col[39:36]
  input  logic                              s_tuser,  // cmd[0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [cog_pkg::M_TDATA_W-1:0]     m_tdata,  // cell_value[7:0]
  output logic [1:0]                        m_tuser   // status[1:0]
);
  import cog_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_CLEAR,
    S_READ,
    S_UPDATE,
    S_RESP
  } state_t;

  state_t             state;
  cmd_t               cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [DIM_W-1:0]   row_r;
  logic [DIM_W-1:0]   col_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [OFF_W-1:0]   clr_cnt;
  logic [VALUE_W-1:0] res_value;
  status_t            res_status;

  dir_res_t           dir_res;
  logic               alloc;

  logic [CELL_W-1:0]  mem [MEM_DEPTH];
  logic [CELL_W-1:0]  mem_rdata;
  logic               mem_we;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_addr;
  logic [CELL_W-1:0]  mem_wdata;
  logic [CELL_W-1:0]  cell_inc;
  logic [ADDR_W-1:0]  cell_addr;
  logic [ADDR_W-1:0]  clr_addr;
  logic               s_fire;

  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  cog_dir u_dir (
    .clk   (clk),
    .rst   (rst),
    .key   (key_r),
    .alloc (alloc),
    .res   (dir_res)
  );

  assign alloc = (state == S_DECIDE) && (cmd_r == CMD_ADD) && !dir_res.hit && !dir_res.full;

  assign cell_addr = ADDR_W'(int'(slot_r) * CELLS_PER_CHUNK + int'(row_r) * CHUNK_DIM
                             + int'(col_r));
  assign clr_addr  = ADDR_W'(int'(slot_r) * CELLS_PER_CHUNK + int'(clr_cnt));
  assign cell_inc  = (mem_rdata == CELL_MAX) ? mem_rdata : mem_rdata + CELL_W'(1);

  // The single memory port is shared by the chunk clear, the cell read and
  // the write-back of an incremented count.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = cell_addr;
    mem_wdata = cell_inc;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
      end
      S_READ:   mem_re = 1'b1;
      S_UPDATE: mem_we = (cmd_r == CMD_ADD);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // In S_RESP the result register is loaded below instead.
      if (m_tvalid && m_tready && (state != S_RESP)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            cmd_r <= cmd_t'(s_tuser);
            key_r <= s_tdata[31:0];
            row_r <= wrap_idx(s_tdata[35:32]);
            col_r <= wrap_idx(s_tdata[39:36]);
            state <= S_LOOK;
          end
        end
        S_LOOK: state <= S_DECIDE;
        S_DECIDE: begin
          slot_r  <= dir_res.slot;
          clr_cnt <= '0;
          if (dir_res.hit) begin
            state <= S_READ;
          end else if (cmd_r == CMD_QUERY) begin
            res_value  <= ABSENT_VALUE;
            res_status <= STAT_ABSENT;
            state      <= S_RESP;
          end else if (dir_res.full) begin
            res_value  <= ABSENT_VALUE;
            res_status <= STAT_FULL;
            state      <= S_RESP;
          end else begin
            state <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + OFF_W'(1);
          if (clr_cnt == OFF_W'(CELLS_PER_CHUNK - 1)) begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_UPDATE;
        S_UPDATE: begin
          res_value  <= (cmd_r == CMD_ADD) ? {1'b0, cell_inc} : {1'b0, mem_rdata};
          res_status <= STAT_OK;
          state      <= S_RESP;
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_value;
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> !s_tready)
    else $error("new word accepted while the previous one is in progress");

  a_ok_nonneg: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == STAT_OK) |-> !m_tdata[VALUE_W-1])
    else $error("ok result carries a negative cell value");

  a_fail_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == STAT_ABSENT || m_tuser == STAT_FULL)) |->
      m_tdata == ABSENT_VALUE)
    else $error("failed lookup does not report the absent value");

  a_alloc_clears: assert property (@(posedge clk) disable iff (rst)
    alloc |=> state == S_CLEAR)
    else $error("chunk allocated without a clear sweep");

endmodule
